/* hdl/bnd_pkg.sv */
// bnd_pkg: shared types and constants of the backlight night dimmer
// register indexes, event codes, level limits and the clamp helper
// no dependencies
`timescale 1ns / 1ps

package bnd_pkg;

  // field widths fixed by the event and register formats
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned REQ_W      = 8;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned HOLD_W     = 24;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // (hold_ms + 1) * 1000 fits in 34 bits for any 24-bit hold
  localparam int unsigned HOLD_LIMIT_W = 34;

  // fraction bits of the fixed-point percent-to-duty scale
  localparam int unsigned DUTY_FRAC = 16;

  // brightness limits in percent
  localparam logic [PCT_W-1:0] LEVEL_MIN = 7'd5;
  localparam logic [PCT_W-1:0] LEVEL_MAX = 7'd100;

  // microseconds per millisecond
  localparam logic [HOLD_LIMIT_W-1:0] US_PER_MS = 34'd1000;

  // event kinds
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TOUCH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_START = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_DIM_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_LEVEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_START_HOUR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_END_HOUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_HOLD_MS     = 3'd4;

  // register reset values
  localparam logic              NIGHT_DIM_ENABLE_RESET = 1'b1;
  localparam logic [PCT_W-1:0]  NIGHT_LEVEL_RESET      = 7'd25;
  localparam logic [HOUR_W-1:0] NIGHT_START_RESET      = 5'd22;
  localparam logic [HOUR_W-1:0] NIGHT_END_RESET        = 5'd6;
  // (60000 + 1) * 1000
  localparam logic [HOLD_LIMIT_W-1:0] HOLD_LIMIT_RESET = 34'd60001000;

  // clamp a requested percent into the legal brightness range
  function automatic logic [PCT_W-1:0] clamp_level(input logic [REQ_W-1:0] v);
    logic [PCT_W-1:0] r;
    if (v < REQ_W'(LEVEL_MIN)) begin
      r = LEVEL_MIN;
    end else if (v > REQ_W'(LEVEL_MAX)) begin
      r = LEVEL_MAX;
    end else begin
      r = v[PCT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/backlight_night_dimmer.sv */
// backlight_night_dimmer: event-driven backlight level and pwm duty control
// one input register, one compare/select pass and one result register
// depends on bnd_pkg
`timescale 1ns / 1ps

//  channel | signals                                  | moves
//  --------+------------------------------------------+--------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser        | one event request
//  m_*     | m_tvalid m_tready m_tdata                | one result per event
//  cfg_*   | cfg_valid cfg_ready cfg_index cfg_data   | one register write
//
//  one event per cycle sustained while m_tready stays high; a taken event goes through
//  the input register, then the state update pass, into the result register
//  rst is synchronous, active high; no clearing pass, the block is ready after reset
//  a stalled result holds in the output register and the input register takes one
//  more event; s_tready drops only when both are full and m_tready is low

module backlight_night_dimmer #(
  parameter int unsigned DUTY_BITS = 13,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic clk,
  input  logic rst,

  // event input
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // tdata: level[7:0], hour[12:8], clock_valid[13], now_us[TIME_BITS+13:14], zero fill
  input  logic [8*((TIME_BITS+14+7)/8)-1:0]      s_tdata,
  // tuser: mode[1:0]
  input  logic [bnd_pkg::MODE_W-1:0]             s_tuser,

  // result output
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // tdata: duty, applied_level, user_level, duty_written, zero fill (lowest first)
  output logic [8*((DUTY_BITS+15+7)/8)-1:0]      m_tdata,

  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bnd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bnd_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int unsigned PCT_W   = bnd_pkg::PCT_W;
  localparam int unsigned HOUR_W  = bnd_pkg::HOUR_W;
  localparam int unsigned REQ_W   = bnd_pkg::REQ_W;
  localparam int unsigned OUT_W   = DUTY_BITS + 2 * PCT_W + 1;
  localparam int unsigned OUT_TD_W = 8 * ((OUT_W + 7) / 8);
  localparam int unsigned CMP_W   = (TIME_BITS > bnd_pkg::HOLD_LIMIT_W) ?
                                    TIME_BITS : bnd_pkg::HOLD_LIMIT_W;
  localparam int unsigned SCALE_W = DUTY_BITS + bnd_pkg::DUTY_FRAC;
  localparam logic [63:0] DUTY_MAX = (64'd1 << DUTY_BITS) - 64'd1;
  // ceil(DUTY_MAX * 2^frac / 100), exact floor for every percent up to 100
  localparam logic [SCALE_W-1:0] DUTY_SCALE =
    SCALE_W'(((DUTY_MAX << bnd_pkg::DUTY_FRAC) + 64'd99) / 64'd100);

  // configuration registers
  logic                                  night_dim_enable;
  logic [PCT_W-1:0]                      night_level;
  logic [HOUR_W-1:0]                     night_start_hour;
  logic [HOUR_W-1:0]                     night_end_hour;
  logic [bnd_pkg::HOLD_LIMIT_W-1:0]      hold_limit;

  // block state
  logic [PCT_W-1:0]     chosen_level, chosen_level_next;
  logic [PCT_W-1:0]     driven_level, driven_level_next;
  logic                 running, running_next;
  logic [TIME_BITS-1:0] last_touch_time, last_touch_time_next;

  // input register
  logic                  in_valid;
  logic [bnd_pkg::MODE_W-1:0] in_mode;
  logic [REQ_W-1:0]      in_level;
  logic [HOUR_W-1:0]     in_hour;
  logic                  in_clock_valid;
  logic [TIME_BITS-1:0]  in_now;

  // result register
  logic                  out_valid;
  logic [DUTY_BITS-1:0]  out_duty;
  logic [PCT_W-1:0]      out_applied;
  logic [PCT_W-1:0]      out_user;
  logic                  out_written;

  // pass signals
  logic                  advance;
  logic [PCT_W-1:0]      req_pct;
  logic                  night_window;
  logic                  in_night;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  hold_over;
  logic [PCT_W-1:0]      night_min;
  logic [PCT_W-1:0]      want;
  logic                  drive_req;
  logic                  written;
  logic [PCT_W+SCALE_W-1:0] duty_prod;

  // handshakes
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_TD_W'({out_written, out_user, out_applied, out_duty});

  // configuration writes; the hold is kept as a microsecond threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      night_dim_enable <= bnd_pkg::NIGHT_DIM_ENABLE_RESET;
      night_level      <= bnd_pkg::NIGHT_LEVEL_RESET;
      night_start_hour <= bnd_pkg::NIGHT_START_RESET;
      night_end_hour   <= bnd_pkg::NIGHT_END_RESET;
      hold_limit       <= bnd_pkg::HOLD_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bnd_pkg::REG_NIGHT_DIM_ENABLE: night_dim_enable <= cfg_data[0];
        bnd_pkg::REG_NIGHT_LEVEL:      night_level      <= cfg_data[PCT_W-1:0];
        bnd_pkg::REG_NIGHT_START_HOUR: night_start_hour <= cfg_data[HOUR_W-1:0];
        bnd_pkg::REG_NIGHT_END_HOUR:   night_end_hour   <= cfg_data[HOUR_W-1:0];
        bnd_pkg::REG_WAKE_HOLD_MS: begin
          hold_limit <= (bnd_pkg::HOLD_LIMIT_W'(cfg_data[bnd_pkg::HOLD_W-1:0])
                         + bnd_pkg::HOLD_LIMIT_W'(1)) * bnd_pkg::US_PER_MS;
        end
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode        <= s_tuser;
      in_level       <= s_tdata[REQ_W-1:0];
      in_hour        <= s_tdata[REQ_W +: HOUR_W];
      in_clock_valid <= s_tdata[REQ_W+HOUR_W];
      in_now         <= s_tdata[REQ_W+HOUR_W+1 +: TIME_BITS];
    end
  end

  // night window, wraps past midnight, empty when the hours are equal
  always_comb begin
    if (night_start_hour == night_end_hour) begin
      night_window = 1'b0;
    end else if (night_start_hour < night_end_hour) begin
      night_window = (in_hour >= night_start_hour) && (in_hour < night_end_hour);
    end else begin
      night_window = (in_hour >= night_start_hour) || (in_hour < night_end_hour);
    end
  end

  assign in_night = night_dim_enable && in_clock_valid && night_window;

  // wake hold: floor(elapsed / 1000) > hold  <=>  elapsed >= (hold + 1) * 1000
  assign elapsed   = in_now - last_touch_time;
  assign hold_over = CMP_W'(elapsed) >= CMP_W'(hold_limit);

  assign req_pct   = bnd_pkg::clamp_level(in_level);
  assign night_min = (chosen_level < night_level) ? chosen_level : night_level;

  // event decode and state update
  always_comb begin
    chosen_level_next    = chosen_level;
    driven_level_next    = driven_level;
    running_next         = running;
    last_touch_time_next = last_touch_time;
    written              = 1'b0;
    want                 = chosen_level;
    drive_req            = 1'b0;
    unique case (in_mode)
      bnd_pkg::MODE_START: begin
        chosen_level_next    = req_pct;
        driven_level_next    = req_pct;
        running_next         = 1'b1;
        last_touch_time_next = in_now;
        written              = 1'b1;
      end
      bnd_pkg::MODE_SET: begin
        chosen_level_next    = req_pct;
        last_touch_time_next = in_now;
        want                 = req_pct;
        drive_req            = 1'b1;
      end
      bnd_pkg::MODE_TOUCH: begin
        last_touch_time_next = in_now;
        drive_req            = driven_level < chosen_level;
      end
      bnd_pkg::MODE_TICK: begin
        if (in_night && hold_over) begin
          want = bnd_pkg::clamp_level(REQ_W'(night_min));
        end
        drive_req = 1'b1;
      end
      default: ;
    endcase
    // start always writes the duty; otherwise it is rewritten only when running and the level really changes
    if (drive_req && running && (want != driven_level)) begin
      driven_level_next = want;
      written           = 1'b1;
    end
  end

  // percent to duty, one fixed-point multiply
  assign duty_prod = (PCT_W+SCALE_W)'(driven_level_next) * (PCT_W+SCALE_W)'(DUTY_SCALE);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chosen_level    <= bnd_pkg::LEVEL_MAX;
      driven_level    <= '0;
      running         <= 1'b0;
      last_touch_time <= '0;
    end else if (advance) begin
      chosen_level    <= chosen_level_next;
      driven_level    <= driven_level_next;
      running         <= running_next;
      last_touch_time <= last_touch_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_duty    <= duty_prod[bnd_pkg::DUTY_FRAC +: DUTY_BITS];
      out_applied <= driven_level_next;
      out_user    <= chosen_level_next;
      out_written <= written;
    end
  end

`ifndef SYNTHESIS
  // once started the block stays started
  a_running_sticks: assert property (@(posedge clk) disable iff (rst)
    running |=> running)
    else $error("running cleared after start");

  // nothing is driven before start
  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    !running |-> (driven_level == '0))
    else $error("level driven before start");

  // a driven level always lies in the legal range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    running |-> (driven_level >= bnd_pkg::LEVEL_MIN) && (driven_level <= bnd_pkg::LEVEL_MAX))
    else $error("driven level out of range");

  // a reported duty write always carries a live level
  a_written_live: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_written) |-> (out_applied >= bnd_pkg::LEVEL_MIN))
    else $error("duty write reported with no level");
`endif

endmodule
